FILE: hdl/pots_pkg.sv
// Package for the periodic and one-shot task timer.
// Holds command and status codes, controller state type and the command struct.
`timescale 1ns / 1ps
`default_nettype none
package pots_pkg;
   typedef enum logic [2:0] {
      CMD_TICK       = 3'd0,
      CMD_PERIODIC   = 3'd1,
      CMD_TIMEOUT    = 3'd2,
      CMD_UNREGISTER = 3'd3,
      CMD_CANCEL     = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_LARGE = 2'd1,
      ST_NO_SLOT   = 2'd2,
      ST_REJECT    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_SCAN = 2'd1,
      S_DONE = 2'd2
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture the request, decode simple commands
      logic scan_step;  // check one slot during a tick scan
      logic finish;     // commit result into the output register
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic is_tick;
      logic scan_last;
   } stat_type;
endpackage
`default_nettype wire

FILE: hdl/pots_ctrl.sv
// Controller state machine of the task timer.
// Depends on pots_pkg; drives the datapath through ctrl_type commands.
`timescale 1ns / 1ps
`default_nettype none
module pots_ctrl
   import pots_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_fire,
   input  wire logic     out_free,
   input  wire stat_type stat,
   output logic          busy,
   output ctrl_type      ctrl
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      ctrl = '0;
      busy = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               ctrl.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.is_tick) begin
               ctrl.scan_step = 1'b1;
               if (stat.scan_last) state_in = S_DONE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               ctrl.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

FILE: hdl/pots_dp.sv
// Datapath of the task timer: slot tables, time base, serial and result.
// Depends on pots_pkg; steered by pots_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module pots_dp
   import pots_pkg::*;
#(
   parameter int unsigned MAX_TASKS = 16
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ctrl_type    ctrl,
   output stat_type         stat,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [31:0] req_interval,
   input  wire logic [15:0] req_handle,
   output logic [1:0]       res_status,
   output logic [15:0]      res_handle,
   output logic [15:0]      res_fired
);
   localparam int unsigned IB = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

   logic [31:0] deadline_ff [MAX_TASKS];
   logic [30:0] period_ff   [MAX_TASKS];
   logic [15:0] handle_ff   [MAX_TASKS];
   logic [MAX_TASKS-1:0] repeats_ff, in_use_ff;
   logic [31:0] now_ff;
   logic [15:0] serial_ff;
   logic [2:0]  cmd_ff;
   logic [1:0]  status_ff;
   logic [15:0] hout_ff, fired_ff;
   logic [IB-1:0] idx_ff;

   logic        found;
   logic [IB-1:0] free_idx;
   logic [31:0] ival;
   logic [31:0] diff;
   logic        due;
   logic [15:0] can_slot;

   always_comb begin
      found = 1'b0;
      free_idx = '0;
      for (int i = MAX_TASKS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            found = 1'b1;
            free_idx = IB'(i);
         end
      end
   end

   assign ival = (req_interval == 32'd0) ? 32'd1 : req_interval;
   assign can_slot = {12'd0, req_handle[3:0]};
   assign diff = deadline_ff[idx_ff] - now_ff;
   assign due = in_use_ff[idx_ff] && (diff == 32'd0 || diff[31]);
   assign stat.is_tick = (cmd_ff == CMD_TICK);
   assign stat.scan_last = (idx_ff == IB'(MAX_TASKS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff <= '0;
         serial_ff <= 16'd1;
         in_use_ff <= '0;
         repeats_ff <= '0;
         cmd_ff <= CMD_TICK;
         idx_ff <= '0;
      end else begin
         if (ctrl.load) begin
            cmd_ff <= req_cmd;
            idx_ff <= '0;
            status_ff <= ST_OK;
            hout_ff <= '0;
            fired_ff <= '0;
            case (req_cmd)
               CMD_TICK: now_ff <= now_ff + 32'd1;
               CMD_PERIODIC, CMD_TIMEOUT: begin
                  if (ival[31]) status_ff <= ST_TOO_LARGE;
                  else if (!found) status_ff <= ST_NO_SLOT;
                  else begin
                     period_ff[free_idx] <= ival[30:0];
                     deadline_ff[free_idx] <= now_ff + ival;
                     in_use_ff[free_idx] <= 1'b1;
                     if (req_cmd == CMD_PERIODIC) begin
                        repeats_ff[free_idx] <= 1'b1;
                        handle_ff[free_idx] <= 16'(free_idx);
                        hout_ff <= 16'(free_idx);
                     end else begin
                        repeats_ff[free_idx] <= 1'b0;
                        handle_ff[free_idx] <= 16'(free_idx) + {serial_ff[11:0], 4'd0};
                        hout_ff <= 16'(free_idx) + {serial_ff[11:0], 4'd0};
                        serial_ff <= serial_ff + 16'd2;
                     end
                  end
               end
               CMD_UNREGISTER: begin
                  if (req_handle >= 16'(MAX_TASKS) || !in_use_ff[req_handle[IB-1:0]])
                     status_ff <= ST_REJECT;
                  else in_use_ff[req_handle[IB-1:0]] <= 1'b0;
               end
               CMD_CANCEL: begin
                  if (can_slot >= 16'(MAX_TASKS) || !in_use_ff[req_handle[IB-1:0]]
                      || repeats_ff[req_handle[IB-1:0]]
                      || handle_ff[req_handle[IB-1:0]] != req_handle)
                     status_ff <= ST_REJECT;
                  else in_use_ff[req_handle[IB-1:0]] <= 1'b0;
               end
               default: status_ff <= ST_REJECT;
            endcase
         end
         if (ctrl.scan_step) begin
            // check one slot a cycle; rearm or free it when due
            if (due) begin
               fired_ff[idx_ff] <= 1'b1;
               if (repeats_ff[idx_ff])
                  deadline_ff[idx_ff] <= now_ff + {1'b0, period_ff[idx_ff]};
               else
                  in_use_ff[idx_ff] <= 1'b0;
            end
            idx_ff <= idx_ff + IB'(1);
         end
      end
   end

   assign res_status = status_ff;
   assign res_handle = hout_ff;
   assign res_fired = fired_ff;
endmodule
`default_nettype wire

FILE: hdl/periodic_and_oneshot_task_timer.sv
// Top level of the periodic and one-shot task timer.
// Depends on pots_pkg, pots_ctrl and pots_dp.
`timescale 1ns / 1ps
`default_nettype none
// A tick transaction has the controller walk the slot table one slot per cycle
// through a single deadline compare and rearm adder. Every other command goes
// through capture, decide and commit steps. The result sits in an output
// register, so one new request is taken while it waits to drain; reqs are
// accepted only when the controller is idle.
module periodic_and_oneshot_task_timer
   import pots_pkg::*;
#(
   parameter int unsigned MAX_TASKS = 16
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,   // cmd[2:0], interval_us[34:3], task_handle[50:35]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // status[1:0], handle_out[17:2], fired_mask[33:18]
);
   ctrl_type ctrl;
   stat_type stat;
   logic busy, req_fire, out_free;
   logic rsp_valid_ff;
   logic [33:0] rsp_data_ff;
   logic [1:0]  res_status;
   logic [15:0] res_handle, res_fired;

   assign req_tready = !busy;
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   pots_ctrl u_ctrl (
      .clock, .reset, .req_fire, .out_free, .stat, .busy, .ctrl
   );

   pots_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
      .clock, .reset, .ctrl, .stat,
      .req_cmd(req_tdata[2:0]), .req_interval(req_tdata[34:3]),
      .req_handle(req_tdata[50:35]),
      .res_status, .res_handle, .res_fired
   );

   // hold the result until the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctrl.finish) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
      if (ctrl.finish) rsp_data_ff <= {res_fired, res_handle, res_status};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {6'd0, rsp_data_ff};

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready) else $error("request taken while busy");
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |-> out_free) else $error("result overwritten");
   a_tick_no_handle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[33:18] != 16'd0) |-> rsp_tdata[17:2] == 16'd0)
      else $error("fired mask with handle");
`endif
endmodule
`default_nettype wire
